// ===== hdl/erafs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// erafs_pkg
// Shared types and constants for the receive address filter and statistics
// block: command word, status and opcode encodings, sizes.
// ---------------------------------------------------------------------------
package erafs_pkg;

   localparam int FILTER_ENTRIES  = 16;
   localparam int MAX_FRAME_BYTES = 1518;
   localparam int MIN_FRAME_BYTES = 14;
   localparam int STAT_COUNT      = 8;
   localparam int QUEUE_DEPTH     = 2;

   localparam int MAC_W   = 48;
   localparam int LEN_W   = 16;
   localparam int STAT_W  = 64;
   localparam int FUNC_W  = 3;
   localparam int SEL_W   = 4;
   localparam int FIDX_W  = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
   localparam int FCNT_W  = $clog2(FILTER_ENTRIES + 1);
   localparam int SIDX_W  = $clog2(STAT_COUNT);
   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   // group bit: LSB of the first octet
   localparam int MCAST_BIT = 40;

   // statistic counter slots
   localparam int C_RX_PKTS  = 0;
   localparam int C_RX_BYTES = 1;
   localparam int C_RX_ERR   = 2;
   localparam int C_RX_DROP  = 3;
   localparam int C_TX_PKTS  = 4;
   localparam int C_TX_BYTES = 5;
   localparam int C_TX_ERR   = 6;
   localparam int C_TX_DROP  = 7;

   typedef enum logic [FUNC_W-1:0] {
      FN_RX   = 3'd0,
      FN_TX   = 3'd1,
      FN_ADD  = 3'd2,
      FN_CLR  = 3'd3,
      FN_STAT = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      OP_RX,
      OP_TX,
      OP_ADD,
      OP_CLR,
      OP_STAT,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_LINK_DOWN = 3'd1,
      ST_BAD_LEN   = 3'd2,
      ST_FILTERED  = 3'd3,
      ST_FULL      = 3'd4,
      ST_BAD_IDX   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_LINK_UP     = 2'd0,
      CSR_PROMISCUOUS = 2'd1,
      CSR_ALL_MCAST   = 2'd2,
      CSR_STATION_MAC = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      BS_IDLE = 3'b001,
      BS_SCAN = 3'b010,
      BS_FIN  = 3'b100
   } back_state_type;

   // classified transaction handed from front to back
   typedef struct packed {
      op_type           op;
      status_type       pre_status;
      logic             need_scan;
      logic [MAC_W-1:0] dest_mac;
      logic [LEN_W-1:0] length;
      logic [MAC_W-1:0] filter_mac;
      logic [SEL_W-1:0] stat_index;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hdl/erafs_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// erafs_front
// Holds the configuration registers, accepts request transactions and
// classifies them: link and length checks, station and multicast matches.
// ---------------------------------------------------------------------------
module erafs_front import erafs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [MAC_W-1:0]  csr_wdata,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [MAC_W-1:0]  req_dest_mac,
   input  wire logic [LEN_W-1:0]  req_frame_length,
   input  wire logic [MAC_W-1:0]  req_filter_mac,
   input  wire logic [SEL_W-1:0]  req_stat_index,
   output logic                   q_push,
   output cmd_type                q_cmd,
   input  wire logic              q_full
);

   logic             link_up_ff;
   logic             promisc_ff;
   logic             all_mcast_ff;
   logic [MAC_W-1:0] station_mac_ff;

   logic    cmd_vld_ff, cmd_vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;
   logic    bad_len;
   logic    addr_hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff     <= 1'b0;
         promisc_ff     <= 1'b0;
         all_mcast_ff   <= 1'b0;
         station_mac_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LINK_UP:     link_up_ff     <= csr_wdata[0];
            CSR_PROMISCUOUS: promisc_ff     <= csr_wdata[0];
            CSR_ALL_MCAST:   all_mcast_ff   <= csr_wdata[0];
            CSR_STATION_MAC: station_mac_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_full = cmd_vld_ff & q_full;
   assign accept   = req_push & ~req_full;

   assign bad_len  = (req_frame_length < LEN_W'(MIN_FRAME_BYTES)) ||
                     (req_frame_length > LEN_W'(MAX_FRAME_BYTES));
   assign addr_hit = promisc_ff || (req_dest_mac == station_mac_ff) ||
                     (all_mcast_ff && req_dest_mac[MCAST_BIT]);

   always_comb begin
      cmd_in            = cmd_ff;
      cmd_vld_in        = cmd_vld_ff & q_full;
      if (accept) begin
         cmd_vld_in        = 1'b1;
         cmd_in.dest_mac   = req_dest_mac;
         cmd_in.length     = req_frame_length;
         cmd_in.filter_mac = req_filter_mac;
         cmd_in.stat_index = req_stat_index;
         cmd_in.need_scan  = 1'b0;
         cmd_in.pre_status = ST_OK;
         case (req_func)
            FN_RX:   cmd_in.op = OP_RX;
            FN_TX:   cmd_in.op = OP_TX;
            FN_ADD:  cmd_in.op = OP_ADD;
            FN_CLR:  cmd_in.op = OP_CLR;
            FN_STAT: cmd_in.op = OP_STAT;
            default: cmd_in.op = OP_NOP;
         endcase
         // link down wins over length
         if (!link_up_ff)
            cmd_in.pre_status = ST_LINK_DOWN;
         else if (bad_len)
            cmd_in.pre_status = ST_BAD_LEN;
         cmd_in.need_scan = ~addr_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cmd_vld_ff <= 1'b0;
      else
         cmd_vld_ff <= cmd_vld_in;
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign q_push = cmd_vld_ff;
   assign q_cmd  = cmd_ff;

endmodule
`default_nettype wire

// ===== hdl/erafs_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// erafs_queue
// Short FIFO of classified transactions between front and back.
// ---------------------------------------------------------------------------
module erafs_queue import erafs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         vld,
   output cmd_type      pop_cmd,
   input  wire logic    pop
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign vld     = (cnt_ff != '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & vld;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_cmd;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not follow push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with empty count");

endmodule
`default_nettype wire

// ===== hdl/erafs_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// erafs_back
// Executes classified transactions: filter table scan, table updates,
// statistic counters and the result register.
// ---------------------------------------------------------------------------
module erafs_back import erafs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_vld,
   input  wire cmd_type           q_cmd,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [2:0]             rsp_status,
   output logic [LEN_W-1:0]       rsp_accepted_length,
   output logic [STAT_W-1:0]      rsp_stat_value
);

   back_state_type     state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   status_type         st_ff, st_in;
   logic [FCNT_W-1:0]  count_ff, count_in;
   logic [FCNT_W-1:0]  issue_ff, issue_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               cmp_last_ff, cmp_last_in;
   logic [MAC_W-1:0]   table_mem [FILTER_ENTRIES];
   logic [MAC_W-1:0]   rdata_ff;
   logic [FIDX_W-1:0]  rd_addr;

   logic [STAT_W-1:0]  stat_ff [STAT_COUNT];
   logic [STAT_COUNT-1:0] cnt_en;

   logic               res_vld_ff, res_vld_in;
   status_type         res_st_ff;
   logic [LEN_W-1:0]   res_len_ff;
   logic [STAT_W-1:0]  res_val_ff;

   logic               fire;
   logic               is_frame;
   logic               is_rx;
   logic               table_wr;

   assign fire     = (state_ff == BS_FIN) && (!res_vld_ff || rsp_pop);
   assign is_frame = (cur_ff.op == OP_RX) || (cur_ff.op == OP_TX);
   assign is_rx    = (cur_ff.op == OP_RX);
   assign table_wr = fire && (cur_ff.op == OP_ADD) && (st_ff == ST_OK);
   assign rd_addr  = issue_ff[FIDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      st_in       = st_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = 1'b0;
      cmp_last_in = cmp_last_ff;
      q_pop       = 1'b0;
      case (state_ff)
         BS_IDLE: begin
            if (q_vld) begin
               q_pop    = 1'b1;
               cur_in   = q_cmd;
               st_in    = ST_OK;
               state_in = BS_FIN;
               issue_in = '0;
               case (q_cmd.op)
                  OP_RX, OP_TX: begin
                     if (q_cmd.pre_status != ST_OK)
                        st_in = q_cmd.pre_status;
                     else if (q_cmd.op == OP_RX && q_cmd.need_scan && count_ff != '0)
                        state_in = BS_SCAN;
                  end
                  OP_ADD:
                     if (count_ff == FCNT_W'(FILTER_ENTRIES))
                        st_in = ST_FULL;
                  OP_STAT:
                     if ({1'b0, q_cmd.stat_index} >= (SEL_W+1)'(STAT_COUNT))
                        st_in = ST_BAD_IDX;
                  default: ;
               endcase
            end
         end
         BS_SCAN: begin
            // one table read issued per cycle, compared in the next cycle
            if (issue_ff < count_ff) begin
               issue_in    = issue_ff + 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_last_in = ((issue_ff + 1'b1) == count_ff);
            end
            if (cmp_vld_ff && rdata_ff == cur_ff.dest_mac) begin
               st_in      = ST_OK;
               state_in   = BS_FIN;
               cmp_vld_in = 1'b0;
            end else if (cmp_vld_ff && cmp_last_ff) begin
               st_in      = ST_FILTERED;
               state_in   = BS_FIN;
               cmp_vld_in = 1'b0;
            end
         end
         BS_FIN: begin
            if (fire) begin
               state_in = BS_IDLE;
               if (table_wr)
                  count_in = count_ff + 1'b1;
               else if (cur_ff.op == OP_CLR)
                  count_in = '0;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BS_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      st_ff       <= st_in;
      issue_ff    <= issue_in;
      cmp_last_ff <= cmp_last_in;
   end

   // filter table
   always_ff @(posedge clock) begin
      if (table_wr)
         table_mem[count_ff[FIDX_W-1:0]] <= cur_ff.filter_mac;
      rdata_ff <= table_mem[rd_addr];
   end

   // counter enables for the finishing transaction
   always_comb begin
      cnt_en = '0;
      if (fire && is_frame) begin
         case (st_ff)
            ST_LINK_DOWN, ST_FILTERED:
               if (is_rx) cnt_en[C_RX_DROP] = 1'b1;
               else       cnt_en[C_TX_DROP] = 1'b1;
            ST_BAD_LEN:
               if (is_rx) cnt_en[C_RX_ERR] = 1'b1;
               else       cnt_en[C_TX_ERR] = 1'b1;
            ST_OK:
               if (is_rx) begin
                  cnt_en[C_RX_PKTS]  = 1'b1;
                  cnt_en[C_RX_BYTES] = 1'b1;
               end else begin
                  cnt_en[C_TX_PKTS]  = 1'b1;
                  cnt_en[C_TX_BYTES] = 1'b1;
               end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAT_COUNT; i++) begin
         if (reset)
            stat_ff[i] <= '0;
         else if (cnt_en[i]) begin
            if (i == C_RX_BYTES || i == C_TX_BYTES)
               stat_ff[i] <= stat_ff[i] + {{(STAT_W-LEN_W){1'b0}}, cur_ff.length};
            else
               stat_ff[i] <= stat_ff[i] + 1'b1;
         end
      end
   end

   // result register
   assign res_vld_in = fire | (res_vld_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset)
         res_vld_ff <= 1'b0;
      else
         res_vld_ff <= res_vld_in;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_st_ff  <= st_ff;
         res_len_ff <= (is_frame && st_ff == ST_OK) ? cur_ff.length : '0;
         res_val_ff <= (cur_ff.op == OP_STAT && st_ff == ST_OK) ?
                       stat_ff[cur_ff.stat_index[SIDX_W-1:0]] : '0;
      end
   end

   assign rsp_empty           = ~res_vld_ff;
   assign rsp_status          = res_st_ff;
   assign rsp_accepted_length = res_len_ff;
   assign rsp_stat_value      = res_val_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FCNT_W'(FILTER_ENTRIES))
      else $error("filter count beyond table size");

   a_scan_needs_entries: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_SCAN) |-> (count_ff != '0))
      else $error("scan started on empty table");

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(res_vld_ff) |-> $past(state_ff == BS_FIN))
      else $error("result loaded outside finish state");

   a_cmp_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == BS_SCAN))
      else $error("compare pending outside scan");

endmodule
`default_nettype wire

// ===== hdl/ethernet_rx_address_filter_stats.sv =====
`default_nettype none
// An accepted request passes the front register, the queue, the back-end
//   sequencer and the result register before it reaches the rsp ports; a
//   scanning receive also reads up to N table entries, N = entries (<= 16).
// The sequencer takes one transaction at a time, one table read per cycle.
// Reset: synchronous, active high; clears config, filter count, statistics,
//   the queue and the front and result registers. Filter table contents are not cleared.
// ---------------------------------------------------------------------------
// ethernet_rx_address_filter_stats
// Frame descriptor address filter with receive/transmit statistics.
// ---------------------------------------------------------------------------
module ethernet_rx_address_filter_stats import erafs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [MAC_W-1:0]  csr_wdata,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [MAC_W-1:0]  req_dest_mac,
   input  wire logic [LEN_W-1:0]  req_frame_length,
   input  wire logic [MAC_W-1:0]  req_filter_mac,
   input  wire logic [SEL_W-1:0]  req_stat_index,
   output logic                   empty,
   input  wire logic              pop,
   output logic [2:0]             rsp_status,
   output logic [LEN_W-1:0]       rsp_accepted_length,
   output logic [STAT_W-1:0]      rsp_stat_value
);

   logic    fq_push;
   cmd_type fq_cmd;
   logic    fq_full;
   logic    bq_vld;
   cmd_type bq_cmd;
   logic    bq_pop;

   erafs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (push),
      .req_full         (full),
      .req_func         (req_func),
      .req_dest_mac     (req_dest_mac),
      .req_frame_length (req_frame_length),
      .req_filter_mac   (req_filter_mac),
      .req_stat_index   (req_stat_index),
      .q_push           (fq_push),
      .q_cmd            (fq_cmd),
      .q_full           (fq_full)
   );

   erafs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .push_cmd (fq_cmd),
      .full     (fq_full),
      .vld      (bq_vld),
      .pop_cmd  (bq_cmd),
      .pop      (bq_pop)
   );

   erafs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_vld               (bq_vld),
      .q_cmd               (bq_cmd),
      .q_pop               (bq_pop),
      .rsp_empty           (empty),
      .rsp_pop             (pop),
      .rsp_status          (rsp_status),
      .rsp_accepted_length (rsp_accepted_length),
      .rsp_stat_value      (rsp_stat_value)
   );

endmodule
`default_nettype wire

// ===== dv/ethernet_rx_address_filter_stats_checker.sv =====
// ---------------------------------------------------------------------------
// ethernet_rx_address_filter_stats_checker
// Watches the CSR, request and response channels of the address filter,
// keeps its own copy of the settings, filter table and statistics, and
// compares each popped response against the oldest predicted one.
// ---------------------------------------------------------------------------
module ethernet_rx_address_filter_stats_checker import erafs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [MAC_W-1:0]  csr_wdata,
   input  wire logic              push,
   input  wire logic              full,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [MAC_W-1:0]  req_dest_mac,
   input  wire logic [LEN_W-1:0]  req_frame_length,
   input  wire logic [MAC_W-1:0]  req_filter_mac,
   input  wire logic [SEL_W-1:0]  req_stat_index,
   input  wire logic              empty,
   input  wire logic              pop,
   input  wire logic [2:0]        rsp_status,
   input  wire logic [LEN_W-1:0]  rsp_accepted_length,
   input  wire logic [STAT_W-1:0] rsp_stat_value,
   output int                     mismatches,
   output int                     outstanding
);

   typedef struct packed {
      status_type        status;
      logic [LEN_W-1:0]  accepted_length;
      logic [STAT_W-1:0] stat_value;
   } frame_result_type;

   logic              link_up;
   logic              promiscuous;
   logic              all_mcast;
   logic [MAC_W-1:0]  station_mac;
   logic [MAC_W-1:0]  filter_macs [FILTER_ENTRIES];
   int unsigned       filter_used;
   logic [STAT_W-1:0] counters [STAT_COUNT];
   frame_result_type  due_results [$];
   int                fail_count = 0;

   function automatic logic address_passes(input logic [MAC_W-1:0] dmac);
      if (dmac == station_mac)
         return 1'b1;
      for (int i = 0; i < filter_used; i++)
         if (filter_macs[i] == dmac)
            return 1'b1;
      return all_mcast && dmac[MCAST_BIT];
   endfunction

   // updates the shadow state for one request and returns its response
   function automatic frame_result_type filter_and_count(
      input logic [FUNC_W-1:0] fn,
      input logic [MAC_W-1:0]  dmac,
      input logic [LEN_W-1:0]  len,
      input logic [MAC_W-1:0]  fmac,
      input logic [SEL_W-1:0]  sidx
   );
      frame_result_type r;
      logic             rx;
      r = '{ST_OK, '0, '0};
      rx = (fn == FN_RX);
      case (fn)
         FN_RX, FN_TX: begin
            if (!link_up) begin
               r.status = ST_LINK_DOWN;
               counters[rx ? C_RX_DROP : C_TX_DROP] += 1;
            end else if (len < MIN_FRAME_BYTES || len > MAX_FRAME_BYTES) begin
               r.status = ST_BAD_LEN;
               counters[rx ? C_RX_ERR : C_TX_ERR] += 1;
            end else if (rx && !promiscuous && filter_used > 0 && !address_passes(dmac)) begin
               r.status = ST_FILTERED;
               counters[C_RX_DROP] += 1;
            end else begin
               counters[rx ? C_RX_PKTS : C_TX_PKTS] += 1;
               counters[rx ? C_RX_BYTES : C_TX_BYTES] += len;
               r.accepted_length = len;
            end
         end
         FN_ADD: begin
            if (filter_used >= FILTER_ENTRIES) begin
               r.status = ST_FULL;
            end else begin
               filter_macs[filter_used] = fmac;
               filter_used++;
            end
         end
         FN_CLR: filter_used = 0;
         FN_STAT: begin
            if (sidx < STAT_COUNT)
               r.stat_value = counters[sidx[SIDX_W-1:0]];
            else
               r.status = ST_BAD_IDX;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      frame_result_type due;
      if (reset) begin
         link_up     = 1'b0;
         promiscuous = 1'b0;
         all_mcast   = 1'b0;
         station_mac = '0;
         filter_used = 0;
         foreach (counters[i])
            counters[i] = '0;
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINK_UP:     link_up = csr_wdata[0];
               CSR_PROMISCUOUS: promiscuous = csr_wdata[0];
               CSR_ALL_MCAST:   all_mcast = csr_wdata[0];
               CSR_STATION_MAC: station_mac = csr_wdata;
               default: ;
            endcase
         end
         // a response can never belong to a request taken on the same edge
         if (pop && !empty) begin
            if (due_results.size() == 0) begin
               $error("response with none pending: status %0d", rsp_status);
               fail_count++;
            end else begin
               due = due_results.pop_front();
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  fail_count++;
               end
               if (rsp_accepted_length !== due.accepted_length) begin
                  $error("accepted_length: expected %0d, got %0d",
                         due.accepted_length, rsp_accepted_length);
                  fail_count++;
               end
               if (rsp_stat_value !== due.stat_value) begin
                  $error("stat_value: expected %0d, got %0d", due.stat_value,
                         rsp_stat_value);
                  fail_count++;
               end
            end
         end
         if (push && !full)
            due_results.push_back(filter_and_count(req_func, req_dest_mac,
                                                   req_frame_length, req_filter_mac,
                                                   req_stat_index));
      end
      mismatches  <= fail_count;
      outstanding <= due_results.size();
   end

endmodule

// ===== dv/ethernet_rx_address_filter_stats_tb.sv =====
// ---------------------------------------------------------------------------
// ethernet_rx_address_filter_stats_tb
// Drives CSR settings and frame/filter/statistic requests into the address
// filter with random gaps and response back-pressure; the checker scores it.
// ---------------------------------------------------------------------------
module ethernet_rx_address_filter_stats_tb;
   import erafs_pkg::*;

   localparam int PHASE_ITEMS = 290;
   localparam int LONG_HOLD   = 150;
   localparam int STALL_LIMIT = 2000;
   localparam logic [FUNC_W-1:0] FN_FIRST_UNDEFINED = FN_STAT + 1'b1;
   localparam logic [MAC_W-1:0]  DIRECTED_STATION   = 48'h02_A5_5A_C3_3C_01;
   localparam logic [MAC_W-1:0]  MCAST_SAMPLE       = 48'h01_00_5E_00_00_FB;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   csr_index_type     csr_index;
   logic [MAC_W-1:0]  csr_wdata;
   logic              push;
   logic              full;
   logic [FUNC_W-1:0] req_func;
   logic [MAC_W-1:0]  req_dest_mac;
   logic [LEN_W-1:0]  req_frame_length;
   logic [MAC_W-1:0]  req_filter_mac;
   logic [SEL_W-1:0]  req_stat_index;
   logic              empty;
   logic              pop;
   logic [2:0]        rsp_status;
   logic [LEN_W-1:0]  rsp_accepted_length;
   logic [STAT_W-1:0] rsp_stat_value;

   int                mismatches;
   int                outstanding;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                hold_ticket;
   int                items_sent = 0;
   int                quiet_cycles = 0;
   logic [MAC_W-1:0]  station_now = '0;
   logic [MAC_W-1:0]  added_macs [$];

   always #4 clock = ~clock;

   ethernet_rx_address_filter_stats dut (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .push, .full, .req_func, .req_dest_mac, .req_frame_length,
      .req_filter_mac, .req_stat_index, .empty, .pop, .rsp_status,
      .rsp_accepted_length, .rsp_stat_value
   );

   ethernet_rx_address_filter_stats_checker scoreboard (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .push, .full, .req_func, .req_dest_mac, .req_frame_length,
      .req_filter_mac, .req_stat_index, .empty, .pop, .rsp_status,
      .rsp_accepted_length, .rsp_stat_value, .mismatches, .outstanding
   );

   function automatic logic [MAC_W-1:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [SEL_W-1:0] rand_index();
      return SEL_W'($urandom_range(2**SEL_W - 1));
   endfunction

   function automatic logic [SEL_W-1:0] pick_index();
      if ($urandom_range(4) != 0)
         return SEL_W'($urandom_range(STAT_COUNT - 1));
      return rand_index();
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(9))
         0: return LEN_W'($urandom_range(MIN_FRAME_BYTES - 1));
         1: return LEN_W'($urandom_range(2**LEN_W - 1, MAX_FRAME_BYTES + 1));
         2: begin
            case ($urandom_range(5))
               0: return LEN_W'(MIN_FRAME_BYTES - 1);
               1: return LEN_W'(MIN_FRAME_BYTES);
               2: return LEN_W'(MAX_FRAME_BYTES);
               3: return LEN_W'(MAX_FRAME_BYTES + 1);
               4: return '0;
               default: return '1;
            endcase
         end
         default: return LEN_W'($urandom_range(MAX_FRAME_BYTES, MIN_FRAME_BYTES));
      endcase
   endfunction

   // bias destinations toward addresses the filter can actually match
   function automatic logic [MAC_W-1:0] pick_dest();
      logic [MAC_W-1:0] m;
      m = rand_mac();
      case ($urandom_range(9))
         0, 1: m = station_now;
         2, 3, 4: if (added_macs.size() > 0)
            m = added_macs[$urandom_range(added_macs.size() - 1)];
         5: m[MCAST_BIT] = 1'b1;
         6: m = '0;
         7: m = '1;
         default: ;
      endcase
      return m;
   endfunction

   function automatic logic [MAC_W-1:0] pick_filter_mac();
      logic [MAC_W-1:0] m;
      m = rand_mac();
      case ($urandom_range(7))
         0: m = station_now;
         1: m[MCAST_BIT] = 1'b1;
         2: m = '0;
         3: m = '1;
         default: ;
      endcase
      return m;
   endfunction

   // push stays high on return so back-to-back requests need no re-raise
   task automatic send_item(
      input logic [FUNC_W-1:0] fn,
      input logic [MAC_W-1:0]  dmac,
      input logic [LEN_W-1:0]  len,
      input logic [MAC_W-1:0]  fmac,
      input logic [SEL_W-1:0]  sidx
   );
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_func         <= fn;
      req_dest_mac     <= dmac;
      req_frame_length <= len;
      req_filter_mac   <= fmac;
      req_stat_index   <= sidx;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [MAC_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // single-bit registers get random upper bits that must be ignored
   task automatic write_settings(
      input logic             link,
      input logic             promisc,
      input logic             allmc,
      input logic [MAC_W-1:0] mac
   );
      logic [MAC_W-1:0] noise;
      noise = rand_mac();
      csr_write(CSR_LINK_UP, {noise[MAC_W-1:1], link});
      noise = rand_mac();
      csr_write(CSR_PROMISCUOUS, {noise[MAC_W-1:1], promisc});
      noise = rand_mac();
      csr_write(CSR_ALL_MCAST, {noise[MAC_W-1:1], allmc});
      csr_write(CSR_STATION_MAC, mac);
      csr_valid   <= 1'b0;
      station_now = mac;
   endtask

   task automatic send_random_item();
      int               pick;
      int               burst;
      logic [MAC_W-1:0] fmac;
      pick = $urandom_range(99);
      if (pick < 40) begin
         send_item(FN_RX, pick_dest(), pick_length(), rand_mac(), rand_index());
      end else if (pick < 55) begin
         send_item(FN_TX, pick_dest(), pick_length(), rand_mac(), rand_index());
      end else if (pick < 72) begin
         // bursts of adds push the table to full
         burst = ($urandom_range(3) == 0) ? $urandom_range(20, 8) : 1;
         repeat (burst) begin
            fmac = pick_filter_mac();
            send_item(FN_ADD, rand_mac(), pick_length(), fmac, rand_index());
            if (added_macs.size() < 2 * FILTER_ENTRIES)
               added_macs.push_back(fmac);
         end
      end else if (pick < 75) begin
         send_item(FN_CLR, rand_mac(), pick_length(), rand_mac(), rand_index());
         added_macs.delete();
      end else if (pick < 93) begin
         send_item(FN_STAT, rand_mac(), pick_length(), rand_mac(), pick_index());
      end else begin
         send_item(FUNC_W'($urandom_range(2**FUNC_W - 1, FN_FIRST_UNDEFINED)),
                   rand_mac(), pick_length(), rand_mac(), rand_index());
      end
   endtask

   // response side: random pops, plus one long hold-off on request
   initial begin
      int hold_served;
      hold_served = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("ethernet_rx_address_filter_stats: mismatch");
         $finish;
      end
   end

   initial begin
      int               phase_end;
      logic [MAC_W-1:0] mac;
      reset            <= 1'b1;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_LINK_UP;
      csr_wdata        <= '0;
      push             <= 1'b0;
      req_func         <= FN_RX;
      req_dest_mac     <= '0;
      req_frame_length <= '0;
      req_filter_mac   <= '0;
      req_stat_index   <= '0;
      send_idle_pct    <= 0;
      recv_idle_pct    <= 0;
      hold_ticket      <= 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // link is down out of reset: both directions drop, length unchecked
      send_item(FN_RX, rand_mac(), 16'd100, rand_mac(), rand_index());
      send_item(FN_TX, rand_mac(), '0, rand_mac(), rand_index());
      wait_idle();
      write_settings(1'b1, 1'b0, 1'b0, DIRECTED_STATION);

      send_item(FN_RX, rand_mac(), LEN_W'(MIN_FRAME_BYTES - 1), rand_mac(), rand_index());
      send_item(FN_RX, rand_mac(), LEN_W'(MIN_FRAME_BYTES), rand_mac(), rand_index());
      send_item(FN_RX, rand_mac(), LEN_W'(MAX_FRAME_BYTES), rand_mac(), rand_index());
      send_item(FN_TX, rand_mac(), LEN_W'(MAX_FRAME_BYTES + 1), rand_mac(), rand_index());
      send_item(FN_TX, rand_mac(), '1, rand_mac(), rand_index());
      send_item(FN_TX, rand_mac(), '0, rand_mac(), rand_index());
      // empty table accepts anything
      send_item(FN_RX, '1, 16'd64, rand_mac(), rand_index());
      send_item(FN_ADD, rand_mac(), pick_length(), '1, rand_index());
      send_item(FN_RX, '1, LEN_W'(MAX_FRAME_BYTES), rand_mac(), rand_index());
      send_item(FN_RX, DIRECTED_STATION, LEN_W'(MIN_FRAME_BYTES), rand_mac(), rand_index());
      send_item(FN_RX, '0, 16'd100, rand_mac(), rand_index());
      send_item(FN_RX, MCAST_SAMPLE, 16'd100, rand_mac(), rand_index());
      send_item(FN_STAT, rand_mac(), pick_length(), rand_mac(), SEL_W'(C_RX_BYTES));
      send_item(FN_STAT, rand_mac(), pick_length(), rand_mac(), SEL_W'(C_RX_DROP));
      send_item(FN_STAT, rand_mac(), pick_length(), rand_mac(), SEL_W'(C_TX_ERR));
      send_item(FN_STAT, rand_mac(), pick_length(), rand_mac(), SEL_W'(STAT_COUNT));
      send_item(FN_STAT, rand_mac(), pick_length(), rand_mac(), '1);
      send_item(FN_FIRST_UNDEFINED, rand_mac(), pick_length(), rand_mac(), rand_index());
      send_item('1, rand_mac(), pick_length(), rand_mac(), rand_index());
      send_item(FN_CLR, rand_mac(), pick_length(), rand_mac(), rand_index());
      send_item(FN_RX, '0, 16'd100, rand_mac(), rand_index());

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         added_macs.delete();
         send_item(FN_CLR, rand_mac(), pick_length(), rand_mac(), rand_index());
         wait_idle();
         mac = rand_mac();
         case (p)
            0: write_settings(1'b1, 1'b0, 1'b0, mac);
            1: write_settings(1'b1, 1'b0, 1'b1, '1);
            2: write_settings(1'b0, 1'b1, 1'b1, '0);
            3: write_settings(1'b1, 1'b1, 1'b0, mac);
            4: begin
               mac[MCAST_BIT] = 1'b1;
               write_settings(1'b1, 1'b0, 1'b1, mac);
            end
            default: write_settings(1'b1, 1'b0, 1'b0, '0);
         endcase
         send_idle_pct <= (p < 2) ? 26 : (p < 4) ? 70 : 0;
         recv_idle_pct <= (p < 2) ? 70 : (p < 4) ? 26 : 0;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            // stall responses once while requests keep coming
            if (p == 0 && hold_ticket == 0 && items_sent + PHASE_ITEMS / 2 >= phase_end)
               hold_ticket <= 1;
            send_random_item();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("ethernet_rx_address_filter_stats: match");
      else
         $display("ethernet_rx_address_filter_stats: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/erafs_pkg.sv
hdl/erafs_front.sv
hdl/erafs_queue.sv
hdl/erafs_back.sv
hdl/ethernet_rx_address_filter_stats.sv
dv/ethernet_rx_address_filter_stats_checker.sv
dv/ethernet_rx_address_filter_stats_tb.sv
